FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the window and unwrap modules.
// All of them sample on i_clk and are off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/ifpyu_pkg.sv
`default_nettype none

package ifpyu_pkg;

    // Frame geometry
    localparam int FRAME_LENGTH = 18;
    localparam int FILL_W       = $clog2(FRAME_LENGTH + 1);

    // Register reset values
    localparam logic [7:0]  HEADER_RST = 8'h5A;
    localparam logic [15:0] JUMP_RST   = 16'd30000;

    // Register indexes (paddr[2])
    localparam logic REG_HEADER = 1'b0;
    localparam logic REG_JUMP   = 1'b1;

    // Hundredths of a degree in one full turn
    localparam logic signed [31:0] TURN_SCALE = 32'sd36000;

    // Result transfer width: six words, status, turns, total, count
    localparam int TDATA_W = 184;

    // Raw fields picked out of a checked frame
    typedef struct packed {
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
        logic        [15:0] yaw_angle;
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic        [7:0]  device_status;
    } t_frame;

    // Frame plus yaw tracking state after that frame
    typedef struct packed {
        t_frame             frame;
        logic signed [15:0] turns;
        logic        [31:0] frames_seen;
    } t_track;

endpackage

`default_nettype wire

FILE: hw/rtl/ifpyu_window.sv
`default_nettype none
`include "assert_macros.svh"

module ifpyu_window (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [7:0]       i_byte,
    input  wire logic             i_last,
    input  wire logic [7:0]       i_header,
    output logic                  o_ready,
    output logic                  o_valid,
    output ifpyu_pkg::t_frame     o_frame,
    input  wire logic             i_ready
);
    import ifpyu_pkg::*;

    logic [7:0]        r_win [FRAME_LENGTH];
    logic [7:0]        n_win [FRAME_LENGTH];
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic [7:0]        r_sum;
    logic [7:0]        n_sum;
    logic [7:0]        sum_body;
    logic [7:0]        drop;
    logic              r_skip;
    logic              r_vld;
    t_frame            r_frame;
    t_frame            n_frame;
    logic              full_next;
    logic              hit;
    logic              acc;

    assign o_ready = !r_vld || i_ready;
    assign acc     = i_valid && o_ready;
    assign o_valid = r_vld;
    assign o_frame = r_frame;

    // Shifted window, running sum and frame check
    always_comb begin
        drop = (r_fill == FILL_W'(FRAME_LENGTH)) ? r_win[0] : 8'h00;
        for (int i = 0; i < FRAME_LENGTH - 1; i++) begin
            n_win[i] = r_win[i + 1];
        end
        n_win[FRAME_LENGTH - 1] = i_byte;
        sum_body  = r_sum - drop;
        n_sum     = sum_body + i_byte;
        full_next = (r_fill >= FILL_W'(FRAME_LENGTH - 1));
        n_fill    = full_next ? FILL_W'(FRAME_LENGTH) : r_fill + FILL_W'(1);
        hit       = !r_skip && full_next && (n_win[0] == i_header)
                    && (n_win[1] == i_header) && (sum_body == i_byte);
        n_frame.gyro_x        = {n_win[4], n_win[5]};
        n_frame.gyro_y        = {n_win[6], n_win[7]};
        n_frame.gyro_z        = {n_win[8], n_win[9]};
        n_frame.yaw_angle     = {n_win[10], n_win[11]};
        n_frame.roll_angle    = {n_win[12], n_win[13]};
        n_frame.pitch_angle   = {n_win[14], n_win[15]};
        n_frame.device_status = n_win[16];
    end

    // Window control; buffer end clears after the byte is handled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_sum  <= '0;
            r_skip <= 1'b0;
            r_vld  <= 1'b0;
        end else begin
            if (acc) begin
                if (i_last) begin
                    r_fill <= '0;
                    r_sum  <= '0;
                    r_skip <= 1'b0;
                end else if (!r_skip) begin
                    r_fill <= n_fill;
                    r_sum  <= n_sum;
                    r_skip <= hit;
                end
            end
            if (acc && hit) begin
                r_vld <= 1'b1;
            end else if (i_ready) begin
                r_vld <= 1'b0;
            end
        end
    end

    // Window bytes and captured frame
    always_ff @(posedge i_clk) begin
        if (acc && !r_skip) begin
            r_win <= n_win;
        end
        if (acc && hit) begin
            r_frame <= n_frame;
        end
    end

    `ASSERT_PROP(a_fill_max, r_fill <= FILL_W'(FRAME_LENGTH), "window fill past frame length")
    `ASSERT_NEXT(a_skip_set, acc && hit && !i_last, r_skip, "skip not set after frame")

endmodule

`default_nettype wire

FILE: hw/rtl/ifpyu_unwrap.sv
`default_nettype none
`include "assert_macros.svh"

module ifpyu_unwrap (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire ifpyu_pkg::t_frame i_frame,
    input  wire logic [15:0]       i_jump,
    output logic                   o_ready,
    output logic                   o_valid,
    output ifpyu_pkg::t_track      o_track,
    input  wire logic              i_ready
);
    import ifpyu_pkg::*;

    logic [15:0]        r_prev;
    logic signed [15:0] r_turns;
    logic signed [15:0] n_turns;
    logic [31:0]        r_count;
    logic [31:0]        n_count;
    logic               r_vld;
    t_track             r_track;
    logic signed [16:0] diff;
    logic signed [16:0] thr;
    logic               up;
    logic               down;
    logic               load;

    assign o_ready = !r_vld || i_ready;
    assign load    = i_valid && o_ready;
    assign o_valid = r_vld;
    assign o_track = r_track;

    // Yaw step against threshold, saturating turn count
    always_comb begin
        diff    = $signed({1'b0, i_frame.yaw_angle}) - $signed({1'b0, r_prev});
        thr     = $signed({1'b0, i_jump});
        up      = (diff < -thr) && (r_turns != 16'sh7FFF);
        down    = (diff > thr) && (r_turns != 16'sh8000);
        n_turns = r_turns;
        if (up) begin
            n_turns = r_turns + 16'sd1;
        end else if (down) begin
            n_turns = r_turns - 16'sd1;
        end
        n_count = r_count + 32'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_turns <= '0;
            r_count <= '0;
            r_vld   <= 1'b0;
        end else begin
            if (load) begin
                r_prev  <= i_frame.yaw_angle;
                r_turns <= n_turns;
                r_count <= n_count;
                r_vld   <= 1'b1;
            end else if (i_ready) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_track.frame       <= i_frame;
            r_track.turns       <= n_turns;
            r_track.frames_seen <= n_count;
        end
    end

    `ASSERT_NEXT(a_turns_hold, !load, $stable(r_turns), "turn count moved without a frame")

endmodule

`default_nettype wire

FILE: hw/rtl/ifpyu_result.sv
`default_nettype none

module ifpyu_result (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire ifpyu_pkg::t_track         i_track,
    output logic                           o_ready,
    output logic                           o_valid,
    output logic [ifpyu_pkg::TDATA_W-1:0]  o_data,
    input  wire logic                      i_ready
);
    import ifpyu_pkg::*;

    logic               r_vld;
    logic [TDATA_W-1:0] r_data;
    logic signed [31:0] prod;
    logic signed [31:0] total;
    logic               load;

    assign o_ready = !r_vld || i_ready;
    assign load    = i_valid && o_ready;
    assign o_valid = r_vld;
    assign o_data  = r_data;

    // Total yaw = yaw + one turn per count
    always_comb begin
        prod  = 32'(i_track.turns) * TURN_SCALE;
        total = prod + $signed({16'h0000, i_track.frame.yaw_angle});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (load) begin
            r_vld <= 1'b1;
        end else if (i_ready) begin
            r_vld <= 1'b0;
        end
    end

    // Pack first field in the low bits
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= {i_track.frames_seen, total, i_track.turns,
                       i_track.frame.device_status, i_track.frame.pitch_angle,
                       i_track.frame.roll_angle, i_track.frame.yaw_angle,
                       i_track.frame.gyro_z, i_track.frame.gyro_y,
                       i_track.frame.gyro_x};
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/imu_frame_parser_yaw_unwrap.sv
// Path: a byte that completes a valid frame is registered in the window, then in
//   yaw tracking, then in the output register, which raises m_tvalid.
// Throughput: one byte per cycle while s_tready is high; each stage is a one-deep elastic register.
// Reset (synchronous, i_rst_n low): window, turn count, frame count and all
//   valid flags clear; header_byte returns to 0x5A, jump_threshold to 30000.
`default_nettype none

module imu_frame_parser_yaw_unwrap (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // byte stream
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [7:0]                s_tdata,   // [7:0] rx_byte
    input  wire logic                      s_tlast,   // buffer_end
    // result stream
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // [15:0] gyro_x, [31:16] gyro_y, [47:32] gyro_z, [63:48] yaw_angle,
    // [79:64] roll_angle, [95:80] pitch_angle, [103:96] device_status,
    // [119:104] turns, [151:120] total_yaw, [183:152] frames_seen
    output logic [ifpyu_pkg::TDATA_W-1:0]  m_tdata,
    // register port
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [2:0]                paddr,
    input  wire logic [31:0]               pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import ifpyu_pkg::*;

    logic [7:0]  r_header;
    logic [15:0] r_jump;
    logic        wr;
    logic        win_vld;
    logic        unw_rdy;
    t_frame      win_frame;
    logic        unw_vld;
    logic        res_rdy;
    t_track      unw_track;

    // Registers
    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= HEADER_RST;
            r_jump   <= JUMP_RST;
        end else if (wr) begin
            if (paddr[2] == REG_JUMP) begin
                r_jump <= pwdata[15:0];
            end else begin
                r_header <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_HEADER) begin
            prdata = {24'h000000, r_header};
        end else begin
            prdata = {16'h0000, r_jump};
        end
    end

    ifpyu_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_tvalid),
        .i_byte   (s_tdata),
        .i_last   (s_tlast),
        .i_header (r_header),
        .o_ready  (s_tready),
        .o_valid  (win_vld),
        .o_frame  (win_frame),
        .i_ready  (unw_rdy)
    );

    ifpyu_unwrap u_unwrap (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (win_vld),
        .i_frame  (win_frame),
        .i_jump   (r_jump),
        .o_ready  (unw_rdy),
        .o_valid  (unw_vld),
        .o_track  (unw_track),
        .i_ready  (res_rdy)
    );

    ifpyu_result u_result (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (unw_vld),
        .i_track  (unw_track),
        .o_ready  (res_rdy),
        .o_valid  (m_tvalid),
        .o_data   (m_tdata),
        .i_ready  (m_tready)
    );

endmodule

`default_nettype wire
